// ----- rtl/core/iaup_pkg.sv -----
package iaup_pkg;

   // Pipeline shape: two stages of front end, then division stages.
   localparam int NUM_DIV_STAGES = 4;
   localparam int NUM_STAGES     = 2 + NUM_DIV_STAGES;

   localparam int PIX_W   = 8;
   localparam int ALPHA_W = 17;
   localparam int MARK_W  = 16;
   localparam int PROD_W  = 32;
   localparam int NUM_W   = 33;
   localparam int REM_W   = 24;
   localparam int DEN_W   = 17;

   // Quotient bits produced by each division stage.
   localparam int DIV_STEPS = PIX_W / NUM_DIV_STAGES;

   localparam logic [PIX_W-1:0]  PIX_MAX    = 8'hFF;
   localparam logic [MARK_W-1:0] MARK_RESET = 16'hFF00;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

   // Configuration register indexes.
   localparam logic [1:0] REG_MARK_RED   = 2'd0;
   localparam logic [1:0] REG_MARK_GREEN = 2'd1;
   localparam logic [1:0] REG_MARK_BLUE  = 2'd2;

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
   } pipe_ctl_type;

   typedef struct packed {
      logic [PROD_W-1:0] prod;
      logic [DEN_W-1:0]  den;
      logic [PIX_W-1:0]  pix;
      logic              bypass;
   } pre_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [REM_W-1:0] dv;
      logic [PIX_W-1:0] q;
      logic [PIX_W-1:0] pix;
      logic             bypass;
      logic             neg;
      logic             ovf;
   } div_type;

endpackage

// ----- rtl/core/inverse_alpha_unblend_pixel.sv -----
// Inverse alpha unblending of one RGB pixel: each channel is solved for the
// background under a watermark colour, background = (pixel - colour * alpha)
// / (1 - alpha), truncated and clamped to 0..255, and a channel at full
// opacity passes through. The block takes one request per clock unless back
// pressure holds it. One stage multiplies colour by opacity, one forms the
// numerator and the saturation test, and four stages each produce two
// quotient bits of a restoring divider. Back pressure on the result side
// stalls only the stages that are full, so bubbles are absorbed.
// The watermark colour registers reset to 255.0 and are written through the
// csr_ port, which is always ready; write them only while the block is idle.
module inverse_alpha_unblend_pixel (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0 up: pix_red[7:0], pix_green[7:0], pix_blue[7:0],
   // alpha_red[16:0], alpha_green[16:0], alpha_blue[16:0], five zero bits.
   input  logic [79:0] req_tdata,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0 up: out_red[7:0], out_green[7:0], out_blue[7:0].
   output logic [23:0] rsp_tdata,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [iaup_pkg::MARK_W-1:0] mark_red_ff;
   logic [iaup_pkg::MARK_W-1:0] mark_green_ff;
   logic [iaup_pkg::MARK_W-1:0] mark_blue_ff;

   iaup_pkg::pipe_ctl_type ctl;

   logic [iaup_pkg::PIX_W-1:0] out_red;
   logic [iaup_pkg::PIX_W-1:0] out_green;
   logic [iaup_pkg::PIX_W-1:0] out_blue;

   // The colour registers accept a write in every cycle. Writes to an
   // index past the blue register are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_red_ff   <= iaup_pkg::MARK_RESET;
         mark_green_ff <= iaup_pkg::MARK_RESET;
         mark_blue_ff  <= iaup_pkg::MARK_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            iaup_pkg::REG_MARK_RED: begin
               mark_red_ff <= csr_data;
            end
            iaup_pkg::REG_MARK_GREEN: begin
               mark_green_ff <= csr_data;
            end
            iaup_pkg::REG_MARK_BLUE: begin
               mark_blue_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // The valid bits and the per-stage load enables are shared by the three
   // channels, which run in lockstep.
   iaup_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .ctl       (ctl)
   );

   iaup_chan u_chan_red (
      .clock  (clock),
      .ctl    (ctl),
      .pix    (req_tdata[7:0]),
      .alpha  (req_tdata[40:24]),
      .mark   (mark_red_ff),
      .result (out_red)
   );

   iaup_chan u_chan_green (
      .clock  (clock),
      .ctl    (ctl),
      .pix    (req_tdata[15:8]),
      .alpha  (req_tdata[57:41]),
      .mark   (mark_green_ff),
      .result (out_green)
   );

   iaup_chan u_chan_blue (
      .clock  (clock),
      .ctl    (ctl),
      .pix    (req_tdata[23:16]),
      .alpha  (req_tdata[74:58]),
      .mark   (mark_blue_ff),
      .result (out_blue)
   );

   assign rsp_tdata = {out_blue, out_green, out_red};

`ifndef SYNTHESIS
   // When the result side takes data, every stage can move, so the input
   // must be open as well.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("request side blocked while result side is ready");

   // With no result waiting, the pipeline cannot be full and must accept.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request side blocked with empty output stage");

   // A result that was offered and not taken must still be offered.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed or vanished");
`endif

endmodule

// ----- rtl/core/iaup_ctrl.sv -----
module iaup_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   output logic                   out_valid,
   input  logic                   out_ready,
   output iaup_pkg::pipe_ctl_type ctl
);

   logic [iaup_pkg::NUM_STAGES-1:0] valid_ff;
   logic [iaup_pkg::NUM_STAGES-1:0] valid_in;
   logic [iaup_pkg::NUM_STAGES-1:0] ready;

   // A stage may load when it is empty or when its content moves on.
   always_comb begin
      ready[iaup_pkg::NUM_STAGES-1] = !valid_ff[iaup_pkg::NUM_STAGES-1] || out_ready;
      for (int k = iaup_pkg::NUM_STAGES - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   always_comb begin
      if (ready[0]) begin
         valid_in[0] = in_valid;
      end else begin
         valid_in[0] = valid_ff[0];
      end
      for (int k = 1; k < iaup_pkg::NUM_STAGES; k++) begin
         if (ready[k]) begin
            valid_in[k] = valid_ff[k-1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.en    = ready;
   assign in_ready  = ready[0];
   assign out_valid = valid_ff[iaup_pkg::NUM_STAGES-1];

endmodule

// ----- rtl/core/iaup_div_stage.sv -----
module iaup_div_stage (
   input  logic              clock,
   input  logic              en,
   input  iaup_pkg::div_type div_i,
   output iaup_pkg::div_type div_ff
);

   iaup_pkg::div_type div_in;

   // Restoring division steps, two per stage with four stages; the divisor
   // is kept aligned to the quotient bit under test and shifts right once
   // per step.
   always_comb begin
      iaup_pkg::div_type s;
      s = div_i;
      for (int i = 0; i < iaup_pkg::DIV_STEPS; i++) begin
         if (s.rem >= s.dv) begin
            s.rem = s.rem - s.dv;
            s.q   = {s.q[iaup_pkg::PIX_W-2:0], 1'b1};
         end else begin
            s.q   = {s.q[iaup_pkg::PIX_W-2:0], 1'b0};
         end
         s.dv = s.dv >> 1;
      end
      div_in = s;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff <= div_in;
      end
   end

endmodule

// ----- rtl/core/iaup_chan.sv -----
module iaup_chan (
   input  logic                         clock,
   input  iaup_pkg::pipe_ctl_type       ctl,
   input  logic [iaup_pkg::PIX_W-1:0]   pix,
   input  logic [iaup_pkg::ALPHA_W-1:0] alpha,
   input  logic [iaup_pkg::MARK_W-1:0]  mark,
   output logic [iaup_pkg::PIX_W-1:0]   result
);

   iaup_pkg::pre_type pre_ff;
   iaup_pkg::pre_type pre_in;
   iaup_pkg::div_type front_ff;
   iaup_pkg::div_type front_in;
   iaup_pkg::div_type div_chain [iaup_pkg::NUM_DIV_STAGES+1];

   logic [iaup_pkg::NUM_W-1:0] num;
   logic [iaup_pkg::REM_W:0]   den_full;

   // Stage 1: colour times opacity, and the divisor 1 - alpha in Q1.16.
   always_comb begin
      pre_in.prod   = iaup_pkg::PROD_W'(mark) * iaup_pkg::PROD_W'(alpha[15:0]);
      pre_in.den    = iaup_pkg::ALPHA_ONE - alpha;
      pre_in.pix    = pix;
      pre_in.bypass = alpha[16];
   end

   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         pre_ff <= pre_in;
      end
   end

   // Stage 2: numerator, sign, and the saturation test against 256 * den.
   always_comb begin
      num      = {1'b0, pre_ff.pix, 24'h000000} - {1'b0, pre_ff.prod};
      den_full = {pre_ff.den, 8'h00};
      front_in.rem    = num[iaup_pkg::REM_W+7:8];
      front_in.dv     = {pre_ff.den, 7'h00};
      front_in.q      = '0;
      front_in.pix    = pre_ff.pix;
      front_in.bypass = pre_ff.bypass;
      front_in.neg    = num[iaup_pkg::NUM_W-1];
      front_in.ovf    = {1'b0, num[iaup_pkg::REM_W+7:8]} >= den_full;
   end

   always_ff @(posedge clock) begin
      if (ctl.en[1]) begin
         front_ff <= front_in;
      end
   end

   assign div_chain[0] = front_ff;

   for (genvar g = 0; g < iaup_pkg::NUM_DIV_STAGES; g++) begin : g_div
      iaup_div_stage u_div (
         .clock  (clock),
         .en     (ctl.en[g+2]),
         .div_i  (div_chain[g]),
         .div_ff (div_chain[g+1])
      );
   end

   always_comb begin
      if (div_chain[iaup_pkg::NUM_DIV_STAGES].bypass) begin
         result = div_chain[iaup_pkg::NUM_DIV_STAGES].pix;
      end else if (div_chain[iaup_pkg::NUM_DIV_STAGES].neg) begin
         result = '0;
      end else if (div_chain[iaup_pkg::NUM_DIV_STAGES].ovf) begin
         result = iaup_pkg::PIX_MAX;
      end else begin
         result = div_chain[iaup_pkg::NUM_DIV_STAGES].q;
      end
   end

endmodule
